// ===== hdl/vps_pkg.sv =====
// Shared constants, microcode types and the control program of the presence soft-clip core.
package vps_pkg;

    localparam int DEF_TANH_ENTRIES = 256;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int CH_W             = 4;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int STEP_W           = 5;

    typedef logic [STEP_W-1:0] t_step;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EFFECT_ON = 3'd0,
        REG_HP_COEFF  = 3'd1,
        REG_DRIVE     = 3'd2,
        REG_PRESENCE  = 3'd3,
        REG_LEVEL     = 3'd4
    } t_cfg_reg;

    // Program steps.
    localparam t_step ST_HP_MUL   = 5'd0;
    localparam t_step ST_HP_SAT   = 5'd1;
    localparam t_step ST_PRES_MUL = 5'd2;
    localparam t_step ST_MIX      = 5'd3;
    localparam t_step ST_DRV_MUL  = 5'd4;
    localparam t_step ST_DRV      = 5'd5;
    localparam t_step ST_ABS      = 5'd6;
    localparam t_step ST_POS_MUL  = 5'd7;
    localparam t_step ST_INDEX    = 5'd8;
    localparam t_step ST_RD_LO    = 5'd9;
    localparam t_step ST_RD_HI    = 5'd10;
    localparam t_step ST_DIFF     = 5'd11;
    localparam t_step ST_FRAC_MUL = 5'd12;
    localparam t_step ST_INTERP   = 5'd13;
    localparam t_step ST_SIGN     = 5'd14;
    localparam t_step ST_LVL_MUL  = 5'd15;
    localparam t_step ST_OUT      = 5'd16;
    localparam t_step ST_BYPASS   = 5'd17;
    localparam t_step STEP_LAST   = ST_BYPASS;

    typedef enum logic {
        MA_DIFF,
        MA_ACC
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_ALPHA,
        MB_PRESENCE,
        MB_DRIVE,
        MB_ENTRIES,
        MB_FRAC,
        MB_LEVEL
    } t_mul_b;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_HP,
        ACC_MIX,
        ACC_DRV,
        ACC_ABS,
        ACC_DIFF,
        ACC_INTERP,
        ACC_SIGN
    } t_acc_op;

    typedef enum logic [1:0] {
        ROM_NONE,
        ROM_IDX,
        ROM_NEXT
    } t_rom_rd;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PRODUCT,
        OUT_BYPASS
    } t_out_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_OFF,
        JMP_END
    } t_jump;

    // One control word of the program.
    typedef struct packed {
        logic    mul_en;
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        t_acc_op acc_op;
        logic    wr_state;
        logic    ld_sat;
        logic    ld_idx;
        t_rom_rd rom_rd;
        logic    ld_y0;
        t_out_op out_op;
        t_jump   jump;
        t_step   target;
    } t_uword;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic effect_on;
        logic out_busy;
    } t_dp_status;

    localparam t_uword UW_NOP = '{
        mul_en:   1'b0,
        mul_a:    MA_ACC,
        mul_b:    MB_ALPHA,
        acc_op:   ACC_HOLD,
        wr_state: 1'b0,
        ld_sat:   1'b0,
        ld_idx:   1'b0,
        rom_rd:   ROM_NONE,
        ld_y0:    1'b0,
        out_op:   OUT_NONE,
        jump:     JMP_NEXT,
        target:   ST_HP_MUL
    };

    // The control program.
    function automatic t_uword ucode(t_step s);
        t_uword w;
        w = UW_NOP;
        unique case (s)
            ST_HP_MUL: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DIFF;
                w.mul_b  = MB_ALPHA;
                w.jump   = JMP_IF_OFF;
                w.target = ST_BYPASS;
            end
            ST_HP_SAT: begin
                w.acc_op   = ACC_HP;
                w.wr_state = 1'b1;
            end
            ST_PRES_MUL: begin
                w.mul_en = 1'b1;
                w.mul_b  = MB_PRESENCE;
            end
            ST_MIX:      w.acc_op = ACC_MIX;
            ST_DRV_MUL: begin
                w.mul_en = 1'b1;
                w.mul_b  = MB_DRIVE;
            end
            ST_DRV:      w.acc_op = ACC_DRV;
            ST_ABS:      w.acc_op = ACC_ABS;
            ST_POS_MUL: begin
                w.mul_en = 1'b1;
                w.mul_b  = MB_ENTRIES;
                w.ld_sat = 1'b1;
            end
            ST_INDEX:    w.ld_idx = 1'b1;
            ST_RD_LO:    w.rom_rd = ROM_IDX;
            ST_RD_HI: begin
                w.rom_rd = ROM_NEXT;
                w.ld_y0  = 1'b1;
            end
            ST_DIFF:     w.acc_op = ACC_DIFF;
            ST_FRAC_MUL: begin
                w.mul_en = 1'b1;
                w.mul_b  = MB_FRAC;
            end
            ST_INTERP:   w.acc_op = ACC_INTERP;
            ST_SIGN:     w.acc_op = ACC_SIGN;
            ST_LVL_MUL: begin
                w.mul_en = 1'b1;
                w.mul_b  = MB_LEVEL;
            end
            ST_OUT: begin
                w.out_op = OUT_PRODUCT;
                w.jump   = JMP_END;
            end
            ST_BYPASS: begin
                w.out_op = OUT_BYPASS;
                w.jump   = JMP_END;
            end
            default:     w.jump = JMP_END;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/vps_if.sv =====
// Stream and configuration channel interfaces of the presence soft-clip core.
interface vps_in_if import vps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CH_W-1:0]               channel_index;

    modport source (output valid, output sample_in, output channel_index, input ready);
    modport sink   (input valid, input sample_in, input channel_index, output ready);
endinterface

interface vps_out_if import vps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_W-1:0]               out_channel;

    modport source (output valid, output sample_out, output out_channel, input ready);
    modport sink   (input valid, input sample_out, input out_channel, output ready);
endinterface

interface vps_cfg_if import vps_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/vps_tanh_rom.sv =====
// Tanh lookup ROM with registered read, contents computed at elaboration.
module vps_tanh_rom import vps_pkg::*; #(
    parameter int TANH_TABLE_ENTRIES = DEF_TANH_ENTRIES,
    parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rd_en,
    input  logic [$clog2(TANH_TABLE_ENTRIES+1)-1:0]   i_addr,
    output logic [SAMPLE_BITS-1:0]                    o_data
);

    localparam int FRAC = SAMPLE_BITS - 1;

    typedef logic [SAMPLE_BITS-1:0] t_tanh_rom [0:TANH_TABLE_ENTRIES];

    // Restoring long division, used only while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i is tanh(4i/N), built by the addition formula in Q30 from tanh(4/N).
    function automatic t_tanh_rom build_rom();
        t_tanh_rom   rom;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] tq;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] ent;
        int          i;
        h  = (64'd1 << 32) / TANH_TABLE_ENTRIES;
        h2 = (h * h) >> 30;
        h3 = (h2 * h) >> 30;
        h5 = (h3 * h2) >> 30;
        h7 = (h5 * h2) >> 30;
        tq = h - h3 / 64'd3 + (64'd2 * h5) / 64'd15 - (64'd17 * h7) / 64'd315;
        t  = '0;
        for (i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
            ent    = (t + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            rom[i] = ent[SAMPLE_BITS-1:0];
            num    = (t + tq) << 30;
            den    = (64'd1 << 30) + ((t * tq) >> 30);
            t      = udiv64(num + (den >> 1), den);
        end
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = build_rom();

    logic [SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= TANH_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== hdl/vps_seq.sv =====
// Microcode sequencer: step counter, program lookup and conditional jumps.
module vps_seq import vps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_uword     o_cw
);

    logic   r_busy;
    logic   n_busy;
    t_step  r_step;
    t_step  n_step;
    t_uword cw_raw;
    logic   stall;

    assign cw_raw = ucode(r_step);
    // A result step waits while the output register still holds an untaken beat.
    assign stall  = (cw_raw.out_op != OUT_NONE) && i_status.out_busy;
    assign o_cw   = (r_busy && !stall) ? cw_raw : UW_NOP;
    assign o_busy = r_busy;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = ST_HP_MUL;
        end else if (r_busy && !stall) begin
            unique case (cw_raw.jump)
                JMP_NEXT:   n_step = STEP_W'(r_step + 1'b1);
                JMP_IF_OFF: n_step = i_status.effect_on ? STEP_W'(r_step + 1'b1)
                                                        : cw_raw.target;
                JMP_END:    n_busy = 1'b0;
                default:    n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_HP_MUL;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("new sample started while the program is running");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && stall) |=> (r_busy && $stable(r_step)))
        else $error("program moved on while the result step was stalled");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_LAST))
        else $error("step counter left the program");

endmodule

// ===== hdl/vps_datapath.sv =====
// Datapath: config registers, filter state, shared multiplier, accumulator and output register.
module vps_datapath import vps_pkg::*; #(
    parameter int TANH_TABLE_ENTRIES = DEF_TANH_ENTRIES,
    parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_uword                        i_cw,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [CH_W-1:0]               i_channel_index,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_out_ready,
    output t_dp_status                    o_status,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic [CH_W-1:0]               o_out_channel
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int AW   = SAMPLE_BITS + 4;
    localparam int BW   = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
    localparam int PW   = AW + BW + 1;
    localparam int HW   = SAMPLE_BITS + 2;
    localparam int FW   = FRAC + 2;
    localparam int RA_W = $clog2(TANH_TABLE_ENTRIES + 1);

    localparam logic [15:0] ALPHA_MAX = 16'd32768;
    localparam logic [15:0] ALPHA_RST = 16'd32303;
    localparam logic [13:0] DRIVE_MIN = 14'd2048;
    localparam logic [13:0] DRIVE_MAX = 14'd12288;
    localparam logic [13:0] DRIVE_RST = 14'd4096;
    localparam logic [14:0] PRES_MAX  = 15'd26214;
    localparam logic [14:0] PRES_RST  = 15'd0;
    localparam logic [15:0] LEVEL_MIN = 16'd3277;
    localparam logic [15:0] LEVEL_MAX = 16'd32768;
    localparam logic [15:0] LEVEL_RST = 16'd32768;

    localparam logic signed [PW-1:0] HP_HI  = PW'((64'sd1 <<< (HW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] HP_LO  = PW'(-(64'sd1 <<< (HW - 1)));
    localparam logic signed [PW-1:0] OUT_HI = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] OUT_LO = PW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [AW-1:0] ABS_LIMIT = AW'(64'sd1 <<< (SAMPLE_BITS + 1));

    // Configuration registers.
    logic        r_effect_on;
    logic [15:0] r_alpha;
    logic [13:0] r_drive;
    logic [14:0] r_presence;
    logic [15:0] r_level;

    // Current sample.
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [CH_W-1:0]               r_ch;
    logic                          r_slot;

    // Filter state, slot 0 for channel 0 and slot 1 for all others.
    logic signed [SAMPLE_BITS-1:0] r_last_in [2];
    logic signed [HW-1:0]          r_last_hp [2];

    // Working registers.
    logic signed [PW-1:0]   r_p;
    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   n_acc;
    logic                   r_neg;
    logic                   r_sat;
    logic [RA_W-1:0]        r_idx;
    logic [FW-1:0]          r_frac;
    logic [SAMPLE_BITS-1:0] r_y0;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic [CH_W-1:0]               r_out_ch;

    logic                          cfg_we;
    logic                          cfg_clear;
    logic [15:0]                   cfg_alpha;
    logic [13:0]                   cfg_drive;
    logic [14:0]                   cfg_presence;
    logic [15:0]                   cfg_level;
    logic signed [AW-1:0]          diff_in;
    logic signed [AW-1:0]          mul_a;
    logic [BW-1:0]                 mul_b;
    logic signed [PW-1:0]          mul_p;
    logic signed [PW-1:0]          p_r15;
    logic signed [PW-1:0]          p_r12;
    logic signed [PW-1:0]          p_rf;
    logic signed [AW-1:0]          hp_val;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic                          rom_rd_en;
    logic [RA_W-1:0]               rom_addr;
    logic [SAMPLE_BITS-1:0]        rom_q;

    // Register writes saturate to the legal range of each register.
    assign cfg_we       = i_cfg_valid;
    assign cfg_alpha    = (i_cfg_data > ALPHA_MAX) ? ALPHA_MAX : i_cfg_data;
    assign cfg_drive    = (i_cfg_data[13:0] < DRIVE_MIN) ? DRIVE_MIN :
                          (i_cfg_data[13:0] > DRIVE_MAX) ? DRIVE_MAX : i_cfg_data[13:0];
    assign cfg_presence = (i_cfg_data[14:0] > PRES_MAX) ? PRES_MAX : i_cfg_data[14:0];
    assign cfg_level    = (i_cfg_data < LEVEL_MIN) ? LEVEL_MIN :
                          (i_cfg_data > LEVEL_MAX) ? LEVEL_MAX : i_cfg_data;
    assign cfg_clear    = cfg_we && (i_cfg_index == REG_EFFECT_ON)
                          && (i_cfg_data[0] != r_effect_on);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_on <= 1'b0;
            r_alpha     <= ALPHA_RST;
            r_drive     <= DRIVE_RST;
            r_presence  <= PRES_RST;
            r_level     <= LEVEL_RST;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_EFFECT_ON: r_effect_on <= i_cfg_data[0];
                REG_HP_COEFF:  r_alpha     <= cfg_alpha;
                REG_DRIVE:     r_drive     <= cfg_drive;
                REG_PRESENCE:  r_presence  <= cfg_presence;
                REG_LEVEL:     r_level     <= cfg_level;
                default: begin
                end
            endcase
        end
    end

    // Shared multiplier: signed operand times unsigned coefficient.
    assign diff_in = AW'(r_last_hp[r_slot]) + AW'(r_x) - AW'(r_last_in[r_slot]);
    assign mul_a   = (i_cw.mul_a == MA_DIFF) ? diff_in : r_acc;

    always_comb begin
        unique case (i_cw.mul_b)
            MB_ALPHA:    mul_b = BW'(r_alpha);
            MB_PRESENCE: mul_b = BW'(r_presence);
            MB_DRIVE:    mul_b = BW'(r_drive);
            MB_ENTRIES:  mul_b = BW'(TANH_TABLE_ENTRIES);
            MB_FRAC:     mul_b = BW'(r_frac);
            MB_LEVEL:    mul_b = BW'(r_level);
            default:     mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Round half up, i.e. floor after adding half an output step.
    assign p_r15 = (r_p + (PW'(1) <<< 14)) >>> 15;
    assign p_r12 = (r_p + (PW'(1) <<< 11)) >>> 12;
    assign p_rf  = (r_p + (PW'(1) <<< (FW - 1))) >>> FW;

    assign hp_val  = (p_r15 > HP_HI) ? AW'(HP_HI) :
                     (p_r15 < HP_LO) ? AW'(HP_LO) : AW'(p_r15);
    assign out_val = (p_r15 > OUT_HI) ? SAMPLE_BITS'(OUT_HI) :
                     (p_r15 < OUT_LO) ? SAMPLE_BITS'(OUT_LO) : SAMPLE_BITS'(p_r15);

    always_comb begin
        unique case (i_cw.acc_op)
            ACC_HOLD:   n_acc = r_acc;
            ACC_HP:     n_acc = hp_val;
            ACC_MIX:    n_acc = AW'(r_x) + AW'(p_r15);
            ACC_DRV:    n_acc = AW'(p_r12);
            ACC_ABS:    n_acc = r_acc[AW-1] ? -r_acc : r_acc;
            ACC_DIFF:   n_acc = AW'($signed({1'b0, rom_q})) - AW'($signed({1'b0, r_y0}));
            ACC_INTERP: n_acc = AW'($signed({1'b0, r_y0})) + AW'(p_rf);
            ACC_SIGN:   n_acc = r_neg ? -r_acc : r_acc;
            default:    n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x    <= i_sample_in;
            r_ch   <= i_channel_index;
            r_slot <= |i_channel_index;
        end
        if (i_cw.mul_en) begin
            r_p <= mul_p;
        end
        r_acc <= n_acc;
        if (i_cw.acc_op == ACC_ABS) begin
            r_neg <= r_acc[AW-1];
        end
        if (i_cw.ld_sat) begin
            r_sat <= (r_acc >= ABS_LIMIT);
        end
        if (i_cw.ld_idx) begin
            r_idx  <= r_sat ? RA_W'(TANH_TABLE_ENTRIES) : r_p[FW +: RA_W];
            r_frac <= r_sat ? '0 : r_p[FW-1:0];
        end
        if (i_cw.ld_y0) begin
            r_y0 <= rom_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            r_last_in[0] <= '0;
            r_last_in[1] <= '0;
            r_last_hp[0] <= '0;
            r_last_hp[1] <= '0;
        end else if (i_cw.wr_state) begin
            r_last_in[r_slot] <= r_x;
            r_last_hp[r_slot] <= HW'(hp_val);
        end
    end

    // Beyond the table the upper neighbor repeats the last entry, with zero fraction.
    assign rom_rd_en = (i_cw.rom_rd != ROM_NONE);
    assign rom_addr  = ((i_cw.rom_rd == ROM_NEXT) && !r_sat) ? RA_W'(r_idx + 1'b1) : r_idx;

    vps_tanh_rom #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (rom_rd_en),
        .i_addr  (rom_addr),
        .o_data  (rom_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cw.out_op != OUT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cw.out_op != OUT_NONE) begin
            r_out_sample <= (i_cw.out_op == OUT_BYPASS) ? r_x : out_val;
            r_out_ch     <= r_ch;
        end
    end

    assign o_status.effect_on = r_effect_on;
    assign o_status.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_sample_out       = r_out_sample;
    assign o_out_channel      = r_out_ch;

    a_state_only_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cw.wr_state |-> r_effect_on)
        else $error("filter state written while the effect is off");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cw.out_op != OUT_NONE) |-> !(r_out_valid && !i_out_ready))
        else $error("result loaded over an untaken output beat");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cw.ld_idx |=> (r_idx <= RA_W'(TANH_TABLE_ENTRIES)))
        else $error("tanh table index beyond the last entry");

endmodule

// ===== hdl/voice_presence_softclip_core.sv =====
// Top level of the voice presence high-pass and tanh soft-clip core.
//
//  channel | dir | modport | payload                         | beat when
//  i_in    | in  | sink    | sample_in, channel_index        | valid && ready
//  o_out   | out | source  | sample_out, out_channel         | valid && ready
//  i_cfg   | in  | sink    | index, data                     | valid && ready
//
// Timing: a result reaches the output register after the program has stepped one shared
// multiplier through its steps (with the effect off it jumps straight to the bypass step);
// the input is ready again only once the program has ended, so one sample is in flight.
// Reset: synchronous, active low; registers take their defaults, filter state clears and
// the sequencer idles. Stalls: the final step holds while the previous result waits in
// the output register; the input waits only for the program, configuration never waits.
//
// Processing per sample: channel 0 uses filter slot 0 and every other channel slot 1.
// The one-pole high-pass output hp = alpha * (last_hp + x - last_x) is saturated and
// stored back, x + hp * presence is driven, and the absolute value indexes the tanh
// table with linear interpolation between neighboring entries; at four and above the
// last entry is used. The sign is restored, output level applied, and the result
// clamped to the sample range. Turning the effect on or off clears both filter slots.
module voice_presence_softclip_core import vps_pkg::*; #(
    parameter int TANH_TABLE_ENTRIES = DEF_TANH_ENTRIES,
    parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vps_in_if.sink    i_in,
    vps_out_if.source o_out,
    vps_cfg_if.sink   i_cfg
);

    logic       busy;
    logic       in_ready;
    logic       accept;
    t_uword     cw;
    t_dp_status status;

    // One sample in flight at a time; the output register decouples the result side.
    assign in_ready    = !busy;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    vps_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_status (status),
        .o_busy   (busy),
        .o_cw     (cw)
    );

    vps_datapath #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cw            (cw),
        .i_accept        (accept),
        .i_sample_in     (i_in.sample_in),
        .i_channel_index (i_in.channel_index),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_status        (status),
        .o_out_valid     (o_out.valid),
        .o_sample_out    (o_out.sample_out),
        .o_out_channel   (o_out.out_channel)
    );

endmodule

// ===== tb/sv/voice_presence_softclip_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the presence high-pass and tanh soft-clip core.
module voice_presence_softclip_core_tb;
    import vps_pkg::*;

    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int FRAC        = SB - 1;
    localparam int ENTRIES     = DEF_TANH_ENTRIES;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 65;
    localparam int SETTLE_CYCLES = 40;

    // Register bounds and reset values.
    localparam int ALPHA_MAX   = 32768;
    localparam int ALPHA_RESET = 32303;
    localparam int DRIVE_MIN   = 2048;
    localparam int DRIVE_MAX   = 12288;
    localparam int DRIVE_RESET = 4096;
    localparam int PRES_MAX    = 26214;
    localparam int PRES_HALF   = 13107;
    localparam int LEVEL_MIN   = 3277;
    localparam int LEVEL_MAX   = 32768;

    // Indexes past the end of the register map; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LAST  = 3'd7;

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct {
        logic signed [SB-1:0] sample;
        logic [CH_W-1:0]      channel;
    } t_out_beat;

    // Scoreboard: keeps its own copy of the registers and the two filter slots,
    // predicts each output beat when its input beat is accepted, and compares
    // output beats in order against the queue of predictions.
    class t_presence_scoreboard;
        longint    tanh_q[ENTRIES+1];
        bit        fx_on;
        longint    alpha, drive, presence, level;
        longint    last_x[2];
        longint    last_hp[2];
        t_out_beat expected_outputs[$];
        int        error_count, samples_noted, results_seen;
        int        wet_samples, past_table;

        function new();
            longint unsigned h, h2, h3, h5, h7, tq, t, num, den;
            // tanh(4/N) by its series in Q30, then the addition formula builds the table.
            h  = (64'd1 << 32) / ENTRIES;
            h2 = (h * h) >> 30;
            h3 = (h2 * h) >> 30;
            h5 = (h3 * h2) >> 30;
            h7 = (h5 * h2) >> 30;
            tq = h - h3 / 3 + (2 * h5) / 15 - (17 * h7) / 315;
            t  = 0;
            for (int i = 0; i <= ENTRIES; i++) begin
                tanh_q[i] = longint'((t + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
                num = (t + tq) << 30;
                den = (64'd1 << 30) + ((t * tq) >> 30);
                t   = (num + den / 2) / den;
            end
            fx_on    = 1'b0;
            alpha    = ALPHA_RESET;
            drive    = DRIVE_RESET;
            presence = 0;
            level    = LEVEL_MAX;
            last_x   = '{0, 0};
            last_hp  = '{0, 0};
        endfunction

        // Narrowing with round half up: floor((v + 2^(s-1)) / 2^s).
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint saturate(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_EFFECT_ON: begin
                    // Any change of the effect switch wipes both filter slots.
                    if (data[0] != fx_on) begin
                        last_x  = '{0, 0};
                        last_hp = '{0, 0};
                    end
                    fx_on = data[0];
                end
                REG_HP_COEFF: alpha    = clamp(longint'(data), 0, ALPHA_MAX);
                REG_DRIVE:    drive    = clamp(longint'(data[13:0]), DRIVE_MIN, DRIVE_MAX);
                REG_PRESENCE: presence = clamp(longint'(data[14:0]), 0, PRES_MAX);
                REG_LEVEL:    level    = clamp(longint'(data), LEVEL_MIN, LEVEL_MAX);
                default: ;
            endcase
        endfunction

        // Predicts the soft-clipped output of one sample and queues it.
        function void note_sample(logic signed [SB-1:0] s, logic [CH_W-1:0] ch);
            longint    x, d, hp, mix, drv, mag, pos, idx, frac, shaped, y;
            int        slot;
            t_out_beat beat;
            x = longint'(s);
            samples_noted++;
            if (!fx_on) begin
                y = x;
            end else begin
                wet_samples++;
                slot = (ch != 0) ? 1 : 0;
                d    = last_hp[slot] + x - last_x[slot];
                hp   = saturate(round_shift(d * alpha, 15), SB + 2);
                last_x[slot]  = x;
                last_hp[slot] = hp;
                mix  = x + round_shift(hp * presence, 15);
                drv  = round_shift(mix * drive, 12);
                mag  = drv < 0 ? -drv : drv;
                if (mag >= (longint'(4) <<< FRAC)) begin
                    past_table++;
                    shaped = tanh_q[ENTRIES];
                end else begin
                    pos    = mag * ENTRIES;
                    idx    = pos >>> (FRAC + 2);
                    frac   = pos - (idx <<< (FRAC + 2));
                    shaped = tanh_q[int'(idx)] + round_shift(
                        (tanh_q[int'(idx) + 1] - tanh_q[int'(idx)]) * frac, FRAC + 2);
                end
                if (drv < 0) begin
                    shaped = -shaped;
                end
                y = saturate(round_shift(shaped * level, 15), SB);
            end
            beat.sample  = y[SB-1:0];
            beat.channel = ch;
            expected_outputs.push_back(beat);
        endfunction

        function void check_result(logic signed [SB-1:0] s, logic [CH_W-1:0] ch);
            t_out_beat want;
            results_seen++;
            if (expected_outputs.size() == 0) begin
                $error("unexpected output beat: sample_out %0d, out_channel %0d", s, ch);
                error_count++;
                return;
            end
            want = expected_outputs.pop_front();
            if (s !== want.sample) begin
                $error("sample_out mismatch: expected %0d, actual %0d", want.sample, s);
                error_count++;
            end
            if (ch !== want.channel) begin
                $error("out_channel mismatch: expected %0d, actual %0d", want.channel, ch);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic rx_ready = 1'b0;
    int   rx_hold = 0;
    int   tx_mode = 0;
    int   rx_mode = 0;
    int   cycle_count = 0;
    int   cfg_writes = 0;
    int   settings_count = 0;

    t_presence_scoreboard sb;

    vps_in_if  #(.SAMPLE_BITS(SB)) in_if ();
    vps_out_if #(.SAMPLE_BITS(SB)) out_if ();
    vps_cfg_if                     cfg_if ();

    assign out_if.ready = rx_ready;

    voice_presence_softclip_core #(
        .TANH_TABLE_ENTRIES(ENTRIES),
        .SAMPLE_BITS       (SB)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle cycles before a beat. Mode 0 never idles, mode 1 idles now and then,
    // mode 2 draws a fresh random idle stretch on every beat.
    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default: return $urandom_range(0, 19);
        endcase
    endfunction

    // Register data: mostly random, sometimes the raw extremes or the exact bounds.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(int lo, int hi);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return lo[CFG_DATA_W-1:0];
            3:       return hi[CFG_DATA_W-1:0];
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    // Output side. Every beat is checked at the edge that moves it; after each
    // beat the receiver drops ready for a freshly drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_hold = 0;
        end else if (out_if.valid && out_if.ready) begin
            sb.check_result(out_if.sample_out, out_if.out_channel);
            rx_hold = draw_wait(rx_mode);
            rx_ready <= (rx_hold == 0);
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            rx_ready <= (rx_hold == 0);
        end else begin
            rx_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sends one sample beat. Valid is only lowered when a gap is drawn, so a
    // back-to-back beat never sees valid lowered and raised in the same step.
    task automatic push_sample(input logic signed [SB-1:0] s, input logic [CH_W-1:0] ch);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.sample_in     <= s;
        in_if.channel_index <= ch;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(s, ch);
    endtask

    // Holds the input back until every predicted output beat has been taken.
    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.note_config(idx, data);
        cfg_writes++;
    endtask

    // Writes the whole register map while the core is idle. The effect switch
    // goes first so that a toggle clears the filters before the new coefficients.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] on_word,
                                  input logic [CFG_DATA_W-1:0] alpha_word,
                                  input logic [CFG_DATA_W-1:0] drive_word,
                                  input logic [CFG_DATA_W-1:0] pres_word,
                                  input logic [CFG_DATA_W-1:0] level_word,
                                  input bit spare);
        wait_for_outputs();
        write_reg(REG_EFFECT_ON, on_word);
        write_reg(REG_HP_COEFF, alpha_word);
        write_reg(REG_DRIVE, drive_word);
        write_reg(REG_PRESENCE, pres_word);
        write_reg(REG_LEVEL, level_word);
        if (spare) begin
            for (int i = IDX_SPARE_FIRST; i <= IDX_SPARE_LAST; i++) begin
                write_reg(i[CFG_INDEX_W-1:0], CFG_DATA_W'($urandom()));
            end
        end
        cfg_if.valid <= 1'b0;
        settings_count++;
    endtask

    initial begin
        logic signed [SB-1:0] s;
        logic [CH_W-1:0]      ch;
        logic [CFG_DATA_W-1:0] on_word;
        longint               walk;
        longint               prev_sample[2];
        int                   frame_pos, frame_len, pick;

        sb = new();
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.sample_in     = '0;
        in_if.channel_index = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_EFFECT_ON;
        cfg_if.data         = '0;
        prev_sample         = '{0, 0};
        frame_pos           = 0;
        frame_len           = 4;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Straight after reset the effect is off, so full-scale
        // samples on the first and last channel must come back untouched.
        tx_mode = 1;
        rx_mode = 1;
        push_sample(SMIN, 0);
        push_sample(SMAX, 15);
        push_sample(0, 1);
        push_sample(-1, 7);

        // Every coefficient register written far above its range so each saturates to its
        // top bound, plus writes to the unused indexes. Full-scale swings with
        // maximum drive push the shaper past the end of the tanh table, and
        // channel 3 then 9 exercise the shared second filter slot.
        apply_settings(16'h0001, '1, '1, '1, '1, 1'b1);
        push_sample(SMAX, 0);
        push_sample(SMIN, 0);
        push_sample(SMAX, 0);
        push_sample(SMIN, 3);
        push_sample(SMAX, 9);
        push_sample(0, 0);
        push_sample(1, 0);
        push_sample(-1, 2);

        // All registers at their low bounds. The effect word has bit 0 set, so
        // the effect stays on and the filter history must survive the write.
        apply_settings('1, '0, '0, '0, '0, 1'b0);
        push_sample(SMAX, 0);
        push_sample(SMIN, 15);
        push_sample(12345, 1);
        push_sample(-20000, 0);

        // Effect off through a word whose upper bits are all set.
        apply_settings(16'hFFFE, CFG_DATA_W'(ALPHA_RESET), CFG_DATA_W'(DRIVE_MAX),
                       CFG_DATA_W'(PRES_MAX), CFG_DATA_W'(LEVEL_MIN), 1'b0);
        push_sample(SMAX, 5);
        push_sample(SMIN, 0);

        // Back on with typical voice settings; both slots start from cleared state.
        apply_settings(16'h0001, CFG_DATA_W'(ALPHA_RESET), CFG_DATA_W'(DRIVE_RESET),
                       CFG_DATA_W'(PRES_HALF), CFG_DATA_W'(LEVEL_MAX), 1'b0);
        push_sample(8000, 0);
        push_sample(16000, 1);
        push_sample(-8000, 0);
        push_sample(-16000, 1);

        // Random part, phase by phase. Each phase picks new register contents
        // (effect mostly on) and a new idle pattern for both sides, so back-pressure stalls
        // land on the result step of the core's program, with stretches of none.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            on_word    = CFG_DATA_W'($urandom());
            on_word[0] = ($urandom_range(0, 6) != 0);
            apply_settings(on_word,
                           pick_setting(0, ALPHA_MAX),
                           pick_setting(DRIVE_MIN, DRIVE_MAX),
                           pick_setting(0, PRES_MAX),
                           pick_setting(LEVEL_MIN, LEVEL_MAX),
                           ($urandom_range(0, 3) == 0));
            tx_mode = p % 3;
            rx_mode = (p / 3) % 3;
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                // Mostly well-ordered frames of 1 to 16 channels, some stray channels.
                if ($urandom_range(0, 9) < 7) begin
                    ch = frame_pos[CH_W-1:0];
                    frame_pos++;
                    if (frame_pos >= frame_len) begin
                        frame_pos = 0;
                        frame_len = $urandom_range(1, 16);
                    end
                end else begin
                    ch = CH_W'($urandom_range(0, 15));
                end
                // Sample content: full-scale peaks, smooth audio-like motion
                // within the slot, or plain noise over the whole range.
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    s = $urandom_range(0, 1) ? SMAX : SMIN;
                end else if (pick < 9) begin
                    walk = prev_sample[ch != 0] + longint'($urandom_range(0, 2047)) - 1024;
                    walk = walk > SMAX ? SMAX : (walk < SMIN ? SMIN : walk);
                    s    = walk[SB-1:0];
                end else begin
                    s = SB'($urandom());
                end
                prev_sample[ch != 0] = longint'(s);
                // Now and then the sender waits for the pipeline to empty.
                if ($urandom_range(0, 49) == 0) begin
                    wait_for_outputs();
                end
                push_sample(s, ch);
            end
        end

        wait_for_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d predicted output beats never arrived", sb.pending());
            sb.error_count++;
        end

        $display("Covered %0d samples: %0d shaped, %0d driven past the tanh table.",
                 sb.samples_noted, sb.wet_samples, sb.past_table);
        $display("Checked %0d output beats; %0d register writes over %0d register settings.",
                 sb.results_seen, cfg_writes, settings_count);
        if (sb.error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/vps_pkg.sv
hdl/vps_if.sv
hdl/vps_tanh_rom.sv
hdl/vps_seq.sv
hdl/vps_datapath.sv
hdl/voice_presence_softclip_core.sv
tb/sv/voice_presence_softclip_core_tb.sv
